>>> rtl/lz77_pkg.sv
// Shared constants and types for the LZ77 token encoder.
package lz77_pkg;

   localparam int WINDOW_DEPTH = 256;
   localparam int DIST_W       = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W        = DIST_W + 1;
   localparam int BYTE_W       = 8;
   localparam int GROUP        = 16;
   localparam int GRP_W        = $clog2(GROUP);
   localparam int NGRP         = WINDOW_DEPTH / GROUP;
   localparam int NGRP_W       = $clog2(NGRP);
   localparam int TDATA_W      = ((2 * DIST_W + BYTE_W + 7) / 8) * 8;

   typedef logic [DIST_W-1:0] dist_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // Controls broadcast from the sequencer to every cell.
   typedef struct packed {
      logic     shift_en;
      logic     clear;
      logic     start;
      byte_type data_byte;
      dist_type lim;
      dist_type cur_len;
   } cell_ctrl_type;

   // Outcome of the search over the cell row.
   typedef struct packed {
      logic     any_keep;
      dist_type best_dist;
      dist_type prev_dist;
   } tree_result_type;

endpackage

>>> rtl/lz77_cell.sv
// One candidate distance: a history byte, its live flag and its prior live flag.
module lz77_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  lz77_pkg::cell_ctrl_type ctrl,
   input  lz77_pkg::dist_type      cand_dist,
   input  lz77_pkg::byte_type      prev_hist,
   output lz77_pkg::byte_type      hist_out,
   output logic                    keep_out,
   output logic                    was_out
);

   lz77_pkg::byte_type hist_ff, hist_in;
   logic               live_ff, live_in;
   logic               was_ff, was_in;
   logic               init;

   always_comb begin
      init    = ctrl.start ? (cand_dist <= ctrl.lim) : live_ff;
      hist_in = hist_ff;
      live_in = live_ff;
      was_in  = was_ff;
      if (ctrl.clear) begin
         hist_in = '0;
         live_in = 1'b0;
         was_in  = 1'b0;
      end else if (ctrl.shift_en) begin
         hist_in = prev_hist;
         live_in = init && (ctrl.cur_len < cand_dist) && (hist_ff == ctrl.data_byte);
         was_in  = init;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         live_ff <= 1'b0;
         was_ff  <= 1'b0;
      end else begin
         hist_ff <= hist_in;
         live_ff <= live_in;
         was_ff  <= was_in;
      end
   end

   assign hist_out = hist_ff;
   assign keep_out = live_ff;
   assign was_out  = was_ff;

endmodule

>>> rtl/lz77_tree.sv
// Two-stage registered search for the largest live and surviving distances.
module lz77_tree (
   input  logic                                 clock,
   input  logic [lz77_pkg::WINDOW_DEPTH-1:0]    keep_vec,
   input  logic [lz77_pkg::WINDOW_DEPTH-1:0]    was_vec,
   output lz77_pkg::tree_result_type            result
);

   logic [lz77_pkg::NGRP-1:0]                       kany_ff, kany_in;
   logic [lz77_pkg::NGRP-1:0]                       wany_ff, wany_in;
   logic [lz77_pkg::NGRP-1:0][lz77_pkg::GRP_W-1:0]  kidx_ff, kidx_in;
   logic [lz77_pkg::NGRP-1:0][lz77_pkg::GRP_W-1:0]  widx_ff, widx_in;
   lz77_pkg::tree_result_type                       res_ff, res_in;

   // Stage one: priority encode each group, highest bit wins.
   always_comb begin
      for (int g = 0; g < lz77_pkg::NGRP; g++) begin
         kany_in[g] = 1'b0;
         wany_in[g] = 1'b0;
         kidx_in[g] = '0;
         widx_in[g] = '0;
         for (int i = 0; i < lz77_pkg::GROUP; i++) begin
            if (keep_vec[g * lz77_pkg::GROUP + i]) begin
               kany_in[g] = 1'b1;
               kidx_in[g] = lz77_pkg::GRP_W'(i);
            end
            if (was_vec[g * lz77_pkg::GROUP + i]) begin
               wany_in[g] = 1'b1;
               widx_in[g] = lz77_pkg::GRP_W'(i);
            end
         end
      end
   end

   // Stage two: pick the highest group and form the distance (index + 1).
   always_comb begin
      res_in = '0;
      for (int g = 0; g < lz77_pkg::NGRP; g++) begin
         if (kany_ff[g]) begin
            res_in.any_keep  = 1'b1;
            res_in.best_dist = lz77_pkg::dist_type'({lz77_pkg::NGRP_W'(g), kidx_ff[g]}) + 1'b1;
         end
         if (wany_ff[g]) begin
            res_in.prev_dist = lz77_pkg::dist_type'({lz77_pkg::NGRP_W'(g), widx_ff[g]}) + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      kany_ff <= kany_in;
      wany_ff <= wany_in;
      kidx_ff <= kidx_in;
      widx_ff <= widx_in;
      res_ff  <= res_in;
   end

   assign result = res_ff;

endmodule

>>> rtl/lz77_token_encoder.sv
// Greedy LZ77 encoder: row of history cells, search tree and token sequencer.
// Sequence: an accepted byte updates the cell row, then passes the two registered
//   stages of the search over the 256-cell row (ST_S1, ST_S2) and the token update
//   step in ST_DONE, which holds while the output stalls; no new byte is taken until then.
// Reset: clears history, candidates, lengths and the output valid flag; search window = 256.
// A final byte clears the history and candidates in the cycle its token is built.
module lz77_token_encoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_byte
   input  logic                          req_tlast,   // final_byte
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lz77_pkg::TDATA_W-1:0]  rsp_tdata,   // [8:0] match_offset,
                                                      // [17:9] match_length,
                                                      // [25:18] next_byte
   output logic                          rsp_tlast,   // stream_end
   input  logic                          csr_wen,
   input  logic [8:0]                    csr_wdata    // search window
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_S1   = 2'd1;
   localparam logic [1:0] ST_S2   = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   localparam int DW = lz77_pkg::DIST_W;

   logic [1:0]                state_ff, state_in;
   logic [DW-1:0]             window_ff, window_in;
   lz77_pkg::dist_type        cur_len_ff, cur_len_in;
   lz77_pkg::dist_type        bbt_ff, bbt_in;
   lz77_pkg::byte_type        byte_ff, byte_in;
   logic                      fin_ff, fin_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lz77_pkg::dist_type        off_ff, off_in;
   lz77_pkg::dist_type        len_ff, len_in;
   lz77_pkg::byte_type        nb_ff, nb_in;
   logic                      end_ff, end_in;

   logic                      accept;
   logic                      emit;
   logic                      clear;
   logic                      out_free;
   lz77_pkg::dist_type        win_eff;
   lz77_pkg::dist_type        len_inc;
   logic [lz77_pkg::SUM_W-1:0] bbt_sum;

   lz77_pkg::cell_ctrl_type   ctrl;
   lz77_pkg::tree_result_type tree_res;
   lz77_pkg::byte_type        hist [lz77_pkg::WINDOW_DEPTH];
   logic [lz77_pkg::WINDOW_DEPTH-1:0] keep_vec;
   logic [lz77_pkg::WINDOW_DEPTH-1:0] was_vec;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign win_eff    = (window_ff > DW'(lz77_pkg::WINDOW_DEPTH)) ?
                       DW'(lz77_pkg::WINDOW_DEPTH) : window_ff;
   assign len_inc    = cur_len_ff + 1'b1;
   assign bbt_sum    = lz77_pkg::SUM_W'(bbt_ff) + lz77_pkg::SUM_W'(cur_len_ff) + 1'b1;

   // Result due unless the match keeps growing on a non-final byte.
   assign emit  = (state_ff == ST_DONE) && (fin_ff || !tree_res.any_keep);
   assign clear = (state_ff == ST_DONE) && fin_ff && out_free;

   always_comb begin
      ctrl.shift_en  = accept;
      ctrl.clear     = clear;
      ctrl.start     = (cur_len_ff == '0);
      ctrl.data_byte = req_tdata;
      ctrl.lim       = (win_eff < bbt_ff) ? win_eff : bbt_ff;
      ctrl.cur_len   = cur_len_ff;
   end

   for (genvar k = 0; k < lz77_pkg::WINDOW_DEPTH; k++) begin : g_cell
      lz77_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .cand_dist (lz77_pkg::dist_type'(k + 1)),
         .prev_hist ((k == 0) ? req_tdata : hist[(k == 0) ? 0 : k - 1]),
         .hist_out  (hist[k]),
         .keep_out  (keep_vec[k]),
         .was_out   (was_vec[k])
      );
   end

   lz77_tree u_tree (
      .clock    (clock),
      .keep_vec (keep_vec),
      .was_vec  (was_vec),
      .result   (tree_res)
   );

   always_comb begin
      state_in     = state_ff;
      window_in    = csr_wen ? csr_wdata : window_ff;
      cur_len_in   = cur_len_ff;
      bbt_in       = bbt_ff;
      byte_in      = accept ? req_tdata : byte_ff;
      fin_in       = accept ? req_tlast : fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      off_in       = off_ff;
      len_in       = len_ff;
      nb_in        = nb_ff;
      end_in       = end_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_S1;
         end
         ST_S1: state_in = ST_S2;
         ST_S2: state_in = ST_DONE;
         ST_DONE: begin
            if (!emit) begin
               // match still growing: extend and wait for the next byte
               cur_len_in = len_inc;
               state_in   = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               end_in       = fin_ff;
               state_in     = ST_IDLE;
               if (tree_res.any_keep) begin
                  off_in = tree_res.best_dist;
                  len_in = len_inc;
                  nb_in  = '0;
               end else begin
                  off_in = (cur_len_ff != '0) ? tree_res.prev_dist : '0;
                  len_in = cur_len_ff;
                  nb_in  = byte_ff;
               end
               if (fin_ff) begin
                  cur_len_in = '0;
                  bbt_in     = '0;
               end else begin
                  cur_len_in = '0;
                  bbt_in     = (bbt_sum > lz77_pkg::SUM_W'(lz77_pkg::WINDOW_DEPTH)) ?
                               DW'(lz77_pkg::WINDOW_DEPTH) : bbt_sum[DW-1:0];
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= DW'(lz77_pkg::WINDOW_DEPTH);
         cur_len_ff   <= '0;
         bbt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         cur_len_ff   <= cur_len_in;
         bbt_ff       <= bbt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      fin_ff  <= fin_in;
      off_ff  <= off_in;
      len_ff  <= len_in;
      nb_ff   <= nb_in;
      end_ff  <= end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = lz77_pkg::TDATA_W'({nb_ff, len_ff, off_ff});
   assign rsp_tlast  = end_ff;

   // A token is a literal exactly when its offset is zero.
   a_literal_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((off_ff == '0) == (len_ff == '0)))
      else $error("literal/offset mismatch");

   // A match never overlaps its own source.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (len_ff <= off_ff))
      else $error("match longer than its offset");

   // An accepted byte always enters the search pipeline.
   a_accept_seq: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_S1))
      else $error("accepted request not sequenced");

endmodule
